// ===== src/njs_pkg.sv =====
// Shared constants and codes for the nonpreemptive job scheduler.
`timescale 1ns / 1ps

package njs_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int unsigned ID_W   = 8;
  localparam int unsigned TIME_W = 16;
  localparam int unsigned RUN_W  = 12;
  localparam int unsigned ENTRY_W = ID_W + TIME_W + RUN_W;
  localparam int unsigned PROD_W  = TIME_W + RUN_W;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 24;

  typedef enum logic {
    CMD_SUBMIT = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_REJECTED = 2'd1,
    ST_RAN      = 2'd2,
    ST_IDLE     = 2'd3
  } status_e;

  typedef enum logic {
    POL_HRRN = 1'b0,
    POL_SPN  = 1'b1
  } policy_e;

  localparam logic REG_POLICY = 1'b0;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] arrival;
    logic [RUN_W-1:0]  run;
  } entry_t;

endpackage

// ===== src/nonpreemptive_job_scheduler.sv =====
// Top level of the nonpreemptive job scheduler: job table, selection scan and run control.
`timescale 1ns / 1ps
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/tready         tuser command, tdata id/arrival/run
//  m_axis    out  m_axis_tvalid/tready         tuser status, tdata cycle/id, tlast finished
//  apb       in   psel/penable/pwrite, pready  policy register at addresses 0-3 (paddr[2] = 0)
//
//  A submit, or a tick while a job runs, goes from accept through the SUBMIT or FINISH
//  state into the output register. A tick with no job running scans every slot through
//  the one table memory port, one slot a cycle with a registered read, then finishes.
//  Reset clears valid bits, clock and run state; the table memory is not cleared.
//  A held result stalls the submit or finish step; one item is worked on at a time.

module nonpreemptive_job_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  // s_axis: tuser = command; tdata = process_id[7:0], arrival_time[23:8],
  //         run_length[35:24], zero pad [39:36]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [njs_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  // m_axis: tuser = status[1:0]; tdata = cycle[15:0], running_id[23:16];
  //         tlast = job_finished
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [njs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [3:0] {
    FSM_IDLE   = 4'b0001,
    FSM_SUBMIT = 4'b0010,
    FSM_SCAN   = 4'b0100,
    FSM_FINISH = 4'b1000
  } fsm_e;

  fsm_e fsm_q, fsm_d;

  logic [njs_pkg::TABLE_DEPTH-1:0] valid_q, valid_d;
  logic [njs_pkg::TIME_W-1:0]      clock_q, clock_d;
  logic                            busy_q, busy_d;
  logic [njs_pkg::ID_W-1:0]        cur_id_q, cur_id_d;
  logic [njs_pkg::RUN_W-1:0]       ticks_q, ticks_d;
  njs_pkg::policy_e                policy_q;

  // latched input word
  njs_pkg::entry_t in_q;

  // scan
  logic [njs_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic                       rd_vld_q, rd_vld_d;
  logic [njs_pkg::SLOT_W-1:0] rd_slot_q;
  logic                       best_vld_q, best_vld_d;
  logic [njs_pkg::SLOT_W-1:0] best_slot_q, best_slot_d;
  logic [njs_pkg::TIME_W-1:0] best_wait_q, best_wait_d;
  njs_pkg::entry_t            best_q, best_d;

  // table memory
  njs_pkg::entry_t            mem_q [njs_pkg::TABLE_DEPTH];
  njs_pkg::entry_t            mem_rd_q;
  logic                       mem_we;
  logic [njs_pkg::SLOT_W-1:0] mem_waddr;

  // output register
  logic                        out_vld_q, out_vld_d, out_load, out_free;
  njs_pkg::status_e            out_status_q, out_status_d;
  logic [njs_pkg::TIME_W-1:0]  out_cycle_q, out_cycle_d;
  logic [njs_pkg::ID_W-1:0]    out_id_q, out_id_d;
  logic                        out_fin_q, out_fin_d;

  logic                       in_fire, cfg_we;
  logic                       free_found;
  logic [njs_pkg::SLOT_W-1:0] free_slot;
  logic                       cand_ok, cand_better;
  logic [njs_pkg::TIME_W-1:0] cand_wait;
  logic [njs_pkg::PROD_W-1:0] prod_cand, prod_best;
  logic                       run_b;
  logic [njs_pkg::ID_W-1:0]   run_id;
  logic [njs_pkg::RUN_W-1:0]  run_ticks, ticks_dec;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (fsm_q == FSM_IDLE);
  assign out_free      = !out_vld_q || m_axis_tready;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == njs_pkg::REG_POLICY);
  assign prdata = {31'd0, policy_q};

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = 0; i < njs_pkg::TABLE_DEPTH; i++) begin
      if (!valid_q[i] && !free_found) begin
        free_found = 1'b1;
        free_slot  = njs_pkg::SLOT_W'(i);
      end
    end
  end

  // candidate compare against the best so far
  assign cand_ok   = rd_vld_q && valid_q[rd_slot_q] && (mem_rd_q.arrival <= clock_q);
  assign cand_wait = clock_q - mem_rd_q.arrival;
  assign prod_cand = njs_pkg::PROD_W'(cand_wait) * njs_pkg::PROD_W'(best_q.run);
  assign prod_best = njs_pkg::PROD_W'(best_wait_q) * njs_pkg::PROD_W'(mem_rd_q.run);

  always_comb begin
    unique case (policy_q)
      njs_pkg::POL_SPN:  cand_better = mem_rd_q.run < best_q.run;
      njs_pkg::POL_HRRN: cand_better = prod_cand > prod_best;
      default:           cand_better = 1'b0;
    endcase
  end

  // run control for the finishing tick
  always_comb begin
    if (!busy_q && best_vld_q) begin
      run_b     = 1'b1;
      run_id    = best_q.id;
      run_ticks = best_q.run;
    end else begin
      run_b     = busy_q;
      run_id    = cur_id_q;
      run_ticks = ticks_q;
    end
  end
  assign ticks_dec = (run_ticks != '0) ? run_ticks - njs_pkg::RUN_W'(1) : run_ticks;

  always_comb begin
    fsm_d        = fsm_q;
    valid_d      = valid_q;
    clock_d      = clock_q;
    busy_d       = busy_q;
    cur_id_d     = cur_id_q;
    ticks_d      = ticks_q;
    cnt_d        = cnt_q;
    rd_vld_d     = 1'b0;
    best_vld_d   = best_vld_q;
    best_slot_d  = best_slot_q;
    best_wait_d  = best_wait_q;
    best_d       = best_q;
    mem_we       = 1'b0;
    mem_waddr    = free_slot;
    out_load     = 1'b0;
    out_status_d = out_status_q;
    out_cycle_d  = out_cycle_q;
    out_id_d     = out_id_q;
    out_fin_d    = out_fin_q;

    unique case (fsm_q)
      FSM_IDLE: begin
        if (in_fire) begin
          best_vld_d = 1'b0;
          cnt_d      = '0;
          if (s_axis_tuser == njs_pkg::CMD_SUBMIT) begin
            fsm_d = FSM_SUBMIT;
          end else if (busy_q) begin
            fsm_d = FSM_FINISH;
          end else begin
            fsm_d = FSM_SCAN;
          end
        end
      end
      FSM_SUBMIT: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_cycle_d = '0;
          out_id_d    = '0;
          out_fin_d   = 1'b0;
          if (free_found && (in_q.run != '0)) begin
            mem_we             = 1'b1;
            valid_d[free_slot] = 1'b1;
            out_status_d       = njs_pkg::ST_ACCEPTED;
          end else begin
            out_status_d = njs_pkg::ST_REJECTED;
          end
          fsm_d = FSM_IDLE;
        end
      end
      FSM_SCAN: begin
        if (cnt_q < njs_pkg::CNT_W'(njs_pkg::TABLE_DEPTH)) begin
          rd_vld_d = 1'b1;
          cnt_d    = cnt_q + njs_pkg::CNT_W'(1);
        end
        // ties keep the earlier, lower slot
        if (cand_ok && (!best_vld_q || cand_better)) begin
          best_vld_d  = 1'b1;
          best_slot_d = rd_slot_q;
          best_wait_d = cand_wait;
          best_d      = mem_rd_q;
        end
        if (rd_vld_q && (rd_slot_q == njs_pkg::SLOT_W'(njs_pkg::TABLE_DEPTH - 1))) begin
          fsm_d = FSM_FINISH;
        end
      end
      FSM_FINISH: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_cycle_d = clock_q;
          if (!busy_q && best_vld_q) begin
            valid_d[best_slot_q] = 1'b0;
          end
          if (run_b) begin
            out_status_d = njs_pkg::ST_RAN;
            out_id_d     = run_id;
            out_fin_d    = (ticks_dec == '0);
            busy_d       = (ticks_dec != '0);
            cur_id_d     = run_id;
            ticks_d      = ticks_dec;
          end else begin
            out_status_d = njs_pkg::ST_IDLE;
            out_id_d     = '0;
            out_fin_d    = 1'b0;
          end
          if (clock_q != '1) begin
            clock_d = clock_q + njs_pkg::TIME_W'(1);
          end
          fsm_d = FSM_IDLE;
        end
      end
      default: fsm_d = FSM_IDLE;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q      <= FSM_IDLE;
      valid_q    <= '0;
      clock_q    <= '0;
      busy_q     <= 1'b0;
      cur_id_q   <= '0;
      ticks_q    <= '0;
      policy_q   <= njs_pkg::POL_HRRN;
      cnt_q      <= '0;
      rd_vld_q   <= 1'b0;
      best_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      fsm_q      <= fsm_d;
      valid_q    <= valid_d;
      clock_q    <= clock_d;
      busy_q     <= busy_d;
      cur_id_q   <= cur_id_d;
      ticks_q    <= ticks_d;
      cnt_q      <= cnt_d;
      rd_vld_q   <= rd_vld_d;
      best_vld_q <= best_vld_d;
      out_vld_q  <= out_vld_d;
      if (cfg_we) begin
        policy_q <= njs_pkg::policy_e'(pwdata[0]);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q.id      <= s_axis_tdata[7:0];
      in_q.arrival <= s_axis_tdata[23:8];
      in_q.run     <= s_axis_tdata[35:24];
    end
    rd_slot_q    <= cnt_q[njs_pkg::SLOT_W-1:0];
    best_slot_q  <= best_slot_d;
    best_wait_q  <= best_wait_d;
    best_q       <= best_d;
    out_status_q <= out_status_d;
    out_cycle_q  <= out_cycle_d;
    out_id_q     <= out_id_d;
    out_fin_q    <= out_fin_d;
  end

  // job table, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= in_q;
    end
    mem_rd_q <= mem_q[cnt_q[njs_pkg::SLOT_W-1:0]];
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_id_q, out_cycle_q};
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_fin_q;

`ifndef SYNTHESIS
  a_busy_has_ticks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (ticks_q != '0))
    else $error("busy with no ticks left");

  a_scan_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q == FSM_SCAN) |-> !busy_q)
    else $error("slot scan while a job runs");

  a_pick_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((fsm_q == FSM_FINISH) && best_vld_q && !busy_q) |-> valid_q[best_slot_q])
    else $error("chosen slot is not valid");

  a_read_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (fsm_q == FSM_SCAN))
    else $error("table read outside scan");

  a_finish_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((fsm_q == FSM_FINISH) && out_free && best_vld_q && !busy_q) |=>
      !valid_q[$past(best_slot_q)])
    else $error("chosen slot not released");
`endif

endmodule

// ===== tb/sv/njs_checker.sv =====
// Checker for the job scheduler: tracks the job table, predicts each result word and compares.
`timescale 1ns / 1ps

module njs_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [njs_pkg::IN_DATA_W-1:0]  in_data_i,   // process_id, arrival_time, run_length, pad
  input  logic                           in_user_i,   // command
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [njs_pkg::OUT_DATA_W-1:0] out_data_i,  // cycle, running_id
  input  logic [1:0]                     out_user_i,  // status
  input  logic                           out_last_i,  // job_finished
  input  logic                           psel_i,
  input  logic                           penable_i,
  input  logic                           pwrite_i,
  input  logic [2:0]                     paddr_i,
  input  logic [31:0]                    pwdata_i,
  input  logic                           pready_i,
  output int unsigned                    outstanding_o,
  output int unsigned                    mismatches_o
);

  typedef struct packed {
    njs_pkg::status_e           status;
    logic [njs_pkg::TIME_W-1:0] cycle;
    logic [njs_pkg::ID_W-1:0]   id;
    logic                       done;
  } report_t;

  // shadow job table and run state
  logic                       slot_used [njs_pkg::TABLE_DEPTH];
  logic [njs_pkg::ID_W-1:0]   slot_pid  [njs_pkg::TABLE_DEPTH];
  logic [njs_pkg::TIME_W-1:0] slot_arr  [njs_pkg::TABLE_DEPTH];
  logic [njs_pkg::RUN_W-1:0]  slot_len  [njs_pkg::TABLE_DEPTH];
  logic [njs_pkg::TIME_W-1:0] now;
  logic                       running;
  logic [njs_pkg::ID_W-1:0]   run_pid;
  logic [njs_pkg::RUN_W-1:0]  remaining;
  njs_pkg::policy_e           pol;

  report_t     report_q [$];
  int unsigned n_bad;

  // true when slot a wins over slot b; HRRN uses exact cross products of wait and run
  function automatic logic preferred(int a, int b);
    logic [njs_pkg::TIME_W-1:0] wait_a, wait_b;
    logic [njs_pkg::PROD_W-1:0] lhs, rhs;
    if (pol == njs_pkg::POL_SPN) return slot_len[a] < slot_len[b];
    wait_a = now - slot_arr[a];
    wait_b = now - slot_arr[b];
    lhs = wait_a * slot_len[b];
    rhs = wait_b * slot_len[a];
    return lhs > rhs;
  endfunction

  function automatic report_t schedule_item(njs_pkg::cmd_e cmd,
                                            logic [njs_pkg::ID_W-1:0] pid,
                                            logic [njs_pkg::TIME_W-1:0] arr,
                                            logic [njs_pkg::RUN_W-1:0] len);
    report_t r;
    int      sel;
    int      i;
    r.status = njs_pkg::ST_ACCEPTED;
    r.cycle  = '0;
    r.id     = '0;
    r.done   = 1'b0;
    sel      = -1;
    if (cmd == njs_pkg::CMD_SUBMIT) begin
      for (i = njs_pkg::TABLE_DEPTH - 1; i >= 0; i--) begin
        if (!slot_used[i]) sel = i;
      end
      if (sel < 0 || len == '0) begin
        r.status = njs_pkg::ST_REJECTED;
      end else begin
        slot_used[sel] = 1'b1;
        slot_pid[sel]  = pid;
        slot_arr[sel]  = arr;
        slot_len[sel]  = len;
      end
    end else begin
      if (!running) begin
        for (i = 0; i < njs_pkg::TABLE_DEPTH; i++) begin
          if (slot_used[i] && slot_arr[i] <= now && (sel < 0 || preferred(i, sel))) sel = i;
        end
        if (sel >= 0) begin
          slot_used[sel] = 1'b0;
          running        = 1'b1;
          run_pid        = slot_pid[sel];
          remaining      = slot_len[sel];
        end
      end
      r.cycle = now;
      if (running) begin
        r.status = njs_pkg::ST_RAN;
        r.id     = run_pid;
        if (remaining != '0) remaining--;
        if (remaining == '0) begin
          r.done  = 1'b1;
          running = 1'b0;
        end
      end else begin
        r.status = njs_pkg::ST_IDLE;
      end
      if (now != '1) now++;
    end
    return r;
  endfunction

  function automatic void check_report(report_t got);
    report_t want;
    if (report_q.size() == 0) begin
      n_bad++;
      if (n_bad <= 10)
        $display("[%0t] unexpected word: status %0d cycle %0d id %0d last %0b",
                 $time, got.status, got.cycle, got.id, got.done);
      return;
    end
    want = report_q.pop_front();
    if (got !== want) begin
      n_bad++;
      if (n_bad <= 10)
        $display("[%0t] mismatch: want status %0d cycle %0d id %0d last %0b, got %0d %0d %0d %0b",
                 $time, want.status, want.cycle, want.id, want.done,
                 got.status, got.cycle, got.id, got.done);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < njs_pkg::TABLE_DEPTH; i++) slot_used[i] = 1'b0;
      now       = '0;
      running   = 1'b0;
      run_pid   = '0;
      remaining = '0;
      pol       = njs_pkg::POL_HRRN;
      n_bad     = 0;
      report_q.delete();
      outstanding_o <= 0;
      mismatches_o  <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i &&
          paddr_i == {njs_pkg::REG_POLICY, 2'b00})
        pol = njs_pkg::policy_e'(pwdata_i[0]);
      if (out_valid_i && out_ready_i)
        check_report({njs_pkg::status_e'(out_user_i), out_data_i[15:0], out_data_i[23:16],
                      out_last_i});
      if (in_valid_i && in_ready_i)
        report_q = {report_q, schedule_item(njs_pkg::cmd_e'(in_user_i), in_data_i[7:0],
                                            in_data_i[23:8], in_data_i[35:24])};
      outstanding_o <= report_q.size();
      mismatches_o  <= n_bad;
    end
  end

endmodule

// ===== tb/sv/tb_nonpreemptive_job_scheduler.sv =====
// Testbench top for the job scheduler: clock, reset, stimulus, stalls, watchdog and verdict.
`timescale 1ns / 1ps

module tb_nonpreemptive_job_scheduler;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned CLOCK_TOP      = 65535;

  logic                           clk     = 1'b0;
  logic                           rst_n   = 1'b0;
  logic                           s_valid = 1'b0;
  logic                           s_ready;
  logic [njs_pkg::IN_DATA_W-1:0]  s_data  = '0;
  logic                           s_user  = 1'b0;
  logic                           m_valid;
  logic                           m_ready = 1'b0;
  logic [njs_pkg::OUT_DATA_W-1:0] m_data;
  logic [1:0]                     m_user;
  logic                           m_last;
  logic                           psel    = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite  = 1'b0;
  logic [2:0]                     paddr   = '0;
  logic [31:0]                    pwdata  = '0;
  logic [31:0]                    prdata;
  logic                           pready;

  int unsigned outstanding;
  int unsigned mismatches;
  int unsigned burst_left = 0;
  int unsigned ticks_sent = 0;
  int unsigned quiet      = 0;
  int unsigned rx_left    = 0;
  int unsigned rx_mode    = 0;

  always #5 clk = ~clk;

  nonpreemptive_job_scheduler u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .m_axis_tlast  (m_last),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  njs_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (s_valid),
    .in_ready_i    (s_ready),
    .in_data_i     (s_data),
    .in_user_i     (s_user),
    .out_valid_i   (m_valid),
    .out_ready_i   (m_ready),
    .out_data_i    (m_data),
    .out_user_i    (m_user),
    .out_last_i    (m_last),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .pready_i      (pready),
    .outstanding_o (outstanding),
    .mismatches_o  (mismatches)
  );

  // receiver: always ready, random, or a sparse periodic window, switching now and then
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 2);
      rx_left <= $urandom_range(20, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0:       m_ready <= 1'b1;
      1:       m_ready <= ($urandom_range(0, 3) != 0);
      default: m_ready <= (rx_left[3:0] < 3);
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // one word on s_axis; called at a clock edge, returns at the accepting edge
  task automatic send_item(input njs_pkg::cmd_e cmd, input logic [njs_pkg::ID_W-1:0] pid,
                           input logic [njs_pkg::TIME_W-1:0] arr,
                           input logic [njs_pkg::RUN_W-1:0] len);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left != 0) burst_left--;
    s_user  <= cmd;
    s_data  <= {4'b0000, len, arr, pid};
    s_valid <= 1'b1;
    do @(posedge clk); while (!s_ready);
    if (cmd == njs_pkg::CMD_TICK && ticks_sent < CLOCK_TOP) ticks_sent++;
  endtask

  task automatic write_policy(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {njs_pkg::REG_POLICY, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_drained();
    s_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // mostly short jobs arriving near the current tick, some rejects and a few long ones
  task automatic random_items(input int unsigned count, input int unsigned submit_pct);
    int unsigned k;
    int unsigned sel;
    int          a;
    logic [njs_pkg::RUN_W-1:0] len;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < submit_pct) begin
        sel = $urandom_range(0, 99);
        a = int'(ticks_sent) + int'($urandom_range(0, 24)) - 16;
        if (a < 0) a = 0;
        if (a > int'(CLOCK_TOP)) a = int'(CLOCK_TOP);
        if (sel < 8) len = '0;
        else if (sel < 82) len = 12'($urandom_range(1, 6));
        else if (sel < 99) len = 12'($urandom_range(7, 40));
        else begin
          len = 12'($urandom_range(1, 4095));
          if ($urandom_range(0, 1) == 1) a = int'($urandom_range(0, CLOCK_TOP));
        end
        send_item(njs_pkg::CMD_SUBMIT, 8'($urandom), 16'(a), len);
      end else begin
        // payload of a tick is ignored; randomize it anyway
        send_item(njs_pkg::CMD_TICK, 8'($urandom), 16'($urandom), 12'($urandom));
      end
    end
  endtask

  logic [31:0] policy_words [4] = '{32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h0000_0001, 32'h0000_0000};

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_policy(32'(njs_pkg::POL_HRRN));

    // directed
    send_item(njs_pkg::CMD_TICK, 8'h00, 16'h0000, 12'h000);      // idle tick at clock zero
    send_item(njs_pkg::CMD_SUBMIT, 8'hFF, 16'h0000, 12'h000);    // zero run length
    send_item(njs_pkg::CMD_SUBMIT, 8'h00, 16'hFFFF, 12'hFFF);    // ready only at the top
    send_item(njs_pkg::CMD_SUBMIT, 8'hA5, 16'h0000, 12'h001);
    send_item(njs_pkg::CMD_SUBMIT, 8'h5A, 16'h0001, 12'h003);
    send_item(njs_pkg::CMD_TICK, 8'hFF, 16'hFFFF, 12'hFFF);
    send_item(njs_pkg::CMD_TICK, 8'h00, 16'h0000, 12'h000);
    send_item(njs_pkg::CMD_SUBMIT, 8'h3C, 16'h0002, 12'h002);    // lands while a job runs
    send_item(njs_pkg::CMD_TICK, 8'h00, 16'h0000, 12'h000);
    send_item(njs_pkg::CMD_TICK, 8'h00, 16'h0000, 12'h000);
    for (int i = 0; i < 15; i++)                         // fill the table, last one bounces
      send_item(njs_pkg::CMD_SUBMIT, 8'(8'h80 + i), 16'(i), 12'(i + 1));

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      write_policy(p < 4 ? policy_words[p] : $urandom);
      random_items(320, $urandom_range(15, 40));
    end
    random_items(40, 30);

    s_valid <= 1'b0;
    wait_drained();
    repeat (25) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
